### rtl/mlcfp_pkg.sv
// Shared types and constants for the marker/length/checksum frame parser.
// Holds the parser phase enum, event codes and the start marker value.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mlcfp_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned KIND_W          = 2;
  localparam int unsigned MAX_PAYLOAD_DEF = 255;

  localparam logic [BYTE_W-1:0] START_MARKER = 8'h3E;  // '>'

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_ID   = 3'd1,
    PH_LEN  = 3'd2,
    PH_HCHK = 3'd3,
    PH_DATA = 3'd4,
    PH_SUM  = 3'd5
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    EV_PAYLOAD = 2'd0,
    EV_GOOD    = 2'd1,
    EV_HDR_ERR = 2'd2,
    EV_SUM_ERR = 2'd3
  } event_kind_t;

endpackage

`default_nettype wire

### rtl/marker_length_checksum_frame_parser.sv
// Top level of the serial frame parser: input register, per-byte parse logic
// and result register with valid/stall handshakes.
// Depends on mlcfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Frame parser for a byte stream of the form
//   '>' id len hdr_chk payload[len] sum
// where hdr_chk must equal (id + len) mod 256 and len must not exceed
// MAX_PAYLOAD. Every payload byte comes out as one transaction of kind
// "payload" carrying its index; the trailing byte is checked against the
// 8-bit sum of the payload and produces a "good" or "checksum error"
// transaction. A bad header produces a "header error" transaction. Bytes
// outside a frame, the marker and the bytes of a good header produce no transaction.
// A '>' inside a frame is plain data. After any report the parser hunts for
// the next marker. Throughput is one byte per clock while the result side
// does not stall: a byte is held in the input register, and the parse state
// and the result register update from it once the result register has room.
// The input register advances whenever the result register is empty or is
// being drained, so the input side keeps moving while a result is taken.
module marker_length_checksum_frame_parser #(
  parameter int unsigned MAX_PAYLOAD = mlcfp_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [mlcfp_pkg::BYTE_W-1:0] in_rx_byte,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [mlcfp_pkg::KIND_W-1:0]     out_event_kind,
  output logic [mlcfp_pkg::BYTE_W-1:0]     out_frame_id,
  output logic [mlcfp_pkg::BYTE_W-1:0]     out_frame_length,
  output logic [mlcfp_pkg::BYTE_W-1:0]     out_payload_index,
  output logic [mlcfp_pkg::BYTE_W-1:0]     out_payload_byte
);
  import mlcfp_pkg::*;

  localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_PAYLOAD);

  // input register
  logic              in_vld_r;
  logic [BYTE_W-1:0] in_byte_r;

  // parse state
  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] cur_id_r, cur_id_nxt;
  logic [BYTE_W-1:0] decl_len_r, decl_len_nxt;
  logic [BYTE_W-1:0] rx_cnt_r, rx_cnt_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;

  // result register
  logic              out_vld_r, out_vld_nxt;
  event_kind_t       kind_r;
  logic [BYTE_W-1:0] fid_r, flen_r, pidx_r, pbyte_r;

  // per-byte result
  logic              res_vld;
  event_kind_t       res_kind;
  logic [BYTE_W-1:0] res_idx, res_byte;

  logic out_free;  // result register can take a new value this cycle
  logic adv;       // byte in the input register is consumed this cycle
  logic hdr_ok;
  logic [BYTE_W-1:0] cnt_inc;

  // Handshake: consume the held byte only when the result side has room.
  assign out_free = !out_vld_r || !out_stall;
  assign adv      = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;

  assign hdr_ok  = (in_byte_r == BYTE_W'(cur_id_r + decl_len_r)) && (decl_len_r <= MAX_LEN);
  assign cnt_inc = BYTE_W'(rx_cnt_r + 1'b1);

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_HUNT: phase_nxt = (in_byte_r == START_MARKER) ? PH_ID : PH_HUNT;
      PH_ID:   phase_nxt = PH_LEN;
      PH_LEN:  phase_nxt = PH_HCHK;
      PH_HCHK: begin
        if (!hdr_ok) begin
          phase_nxt = PH_HUNT;
        end else if (decl_len_r == '0) begin
          phase_nxt = PH_SUM;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: phase_nxt = (cnt_inc == decl_len_r) ? PH_SUM : PH_DATA;
      PH_SUM:  phase_nxt = PH_HUNT;
      default: phase_nxt = (in_byte_r == START_MARKER) ? PH_ID : PH_HUNT;
    endcase
  end

  // Datapath updates and result for the held byte.
  always_comb begin
    cur_id_nxt   = cur_id_r;
    decl_len_nxt = decl_len_r;
    rx_cnt_nxt   = rx_cnt_r;
    sum_nxt      = sum_r;
    res_vld      = 1'b0;
    res_kind     = EV_PAYLOAD;
    res_idx      = '0;
    res_byte     = '0;
    case (phase_r)
      PH_ID: begin
        cur_id_nxt = in_byte_r;
        rx_cnt_nxt = '0;
      end
      PH_LEN: begin
        decl_len_nxt = in_byte_r;
      end
      PH_HCHK: begin
        if (hdr_ok) begin
          sum_nxt = '0;
        end else begin
          res_vld  = 1'b1;
          res_kind = EV_HDR_ERR;
        end
      end
      PH_DATA: begin
        res_vld    = 1'b1;
        res_kind   = EV_PAYLOAD;
        res_idx    = rx_cnt_r;
        res_byte   = in_byte_r;
        sum_nxt    = BYTE_W'(sum_r + in_byte_r);
        rx_cnt_nxt = cnt_inc;
      end
      PH_SUM: begin
        res_vld  = 1'b1;
        res_kind = (in_byte_r == sum_r) ? EV_GOOD : EV_SUM_ERR;
      end
      default: begin
        res_vld = 1'b0;
      end
    endcase
  end

  assign out_vld_nxt = adv ? res_vld : (out_vld_r && out_stall);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      phase_r    <= PH_HUNT;
      cur_id_r   <= '0;
      decl_len_r <= '0;
      rx_cnt_r   <= '0;
      sum_r      <= '0;
    end else begin
      // hold the input register while stalled, otherwise take the next byte
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      out_vld_r <= out_vld_nxt;
      if (adv) begin
        phase_r    <= phase_nxt;
        cur_id_r   <= cur_id_nxt;
        decl_len_r <= decl_len_nxt;
        rx_cnt_r   <= rx_cnt_nxt;
        sum_r      <= sum_nxt;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
    if (adv && res_vld) begin
      kind_r  <= res_kind;
      fid_r   <= cur_id_r;
      flen_r  <= decl_len_r;
      pidx_r  <= res_idx;
      pbyte_r <= res_byte;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_event_kind    = kind_r;
  assign out_frame_id      = fid_r;
  assign out_frame_length  = flen_r;
  assign out_payload_index = pidx_r;
  assign out_payload_byte  = pbyte_r;

  // A payload transaction always lies inside the declared length.
  a_idx_in_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && kind_r == EV_PAYLOAD) |-> (pidx_r < flen_r))
    else $error("payload index beyond declared length");

  // Report transactions carry zero index and byte.
  a_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && kind_r != EV_PAYLOAD) |-> (pidx_r == '0 && pbyte_r == '0))
    else $error("report transaction with nonzero payload fields");

  // Any report sends the parser back to hunting.
  a_report_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res_vld && res_kind != EV_PAYLOAD) |=> (phase_r == PH_HUNT))
    else $error("parser not hunting after a report");

  // A waiting result must not be overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall) |=> (out_vld_r && $stable(pidx_r) && $stable(kind_r)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

### test/parser_event_checker.sv
// Checker for the frame parser: watches both channels, predicts parse events.
// Compares each result transaction with the oldest predicted event.
// Depends on mlcfp_pkg.
`timescale 1ns / 1ps

module parser_event_checker #(
  parameter int unsigned MAX_PAYLOAD = mlcfp_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_stall,
  input  wire logic [mlcfp_pkg::BYTE_W-1:0]  in_rx_byte,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire logic [mlcfp_pkg::KIND_W-1:0]  out_event_kind,
  input  wire logic [mlcfp_pkg::BYTE_W-1:0]  out_frame_id,
  input  wire logic [mlcfp_pkg::BYTE_W-1:0]  out_frame_length,
  input  wire logic [mlcfp_pkg::BYTE_W-1:0]  out_payload_index,
  input  wire logic [mlcfp_pkg::BYTE_W-1:0]  out_payload_byte,
  output int                                 mismatch_count,
  output int                                 pending_count,
  output int                                 good_count,
  output int                                 hdr_err_count,
  output int                                 sum_err_count,
  output int                                 payload_count
);

  import mlcfp_pkg::*;

  typedef struct packed {
    event_kind_t       kind;
    logic [BYTE_W-1:0] frame_id;
    logic [BYTE_W-1:0] frame_length;
    logic [BYTE_W-1:0] index;
    logic [BYTE_W-1:0] data;
  } parse_event_t;

  parse_event_t      expected_events[$];

  // Shadow copy of the parser state.
  phase_t            ph;
  logic [BYTE_W-1:0] cur_id;
  logic [BYTE_W-1:0] decl_len;
  logic [BYTE_W-1:0] rx_count;
  logic [BYTE_W-1:0] run_sum;

  task automatic note_event(input event_kind_t k, input logic [BYTE_W-1:0] idx,
                            input logic [BYTE_W-1:0] dat);
    parse_event_t ev;
    ev.kind         = k;
    ev.frame_id     = cur_id;
    ev.frame_length = decl_len;
    ev.index        = idx;
    ev.data         = dat;
    expected_events = {expected_events, ev};
  endtask

  task automatic parse_rx_byte(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] hdr_sum;
    case (ph)
      PH_ID: begin
        cur_id   = c;
        rx_count = '0;
        ph       = PH_LEN;
      end
      PH_LEN: begin
        decl_len = c;
        ph       = PH_HCHK;
      end
      PH_HCHK: begin
        hdr_sum = cur_id + decl_len;
        if (c == hdr_sum && decl_len <= MAX_PAYLOAD) begin
          run_sum = '0;
          ph      = (decl_len == '0) ? PH_SUM : PH_DATA;
        end else begin
          ph = PH_HUNT;
          note_event(EV_HDR_ERR, '0, '0);
        end
      end
      PH_DATA: begin
        note_event(EV_PAYLOAD, rx_count, c);
        run_sum  = run_sum + c;
        rx_count = rx_count + 8'd1;
        if (rx_count == decl_len) ph = PH_SUM;
      end
      PH_SUM: begin
        ph = PH_HUNT;
        note_event((c == run_sum) ? EV_GOOD : EV_SUM_ERR, '0, '0);
      end
      default: begin
        ph = (c == START_MARKER) ? PH_ID : PH_HUNT;
      end
    endcase
  endtask

  task automatic check_result();
    parse_event_t exp_ev;
    if (expected_events.size() == 0) begin
      $error("unexpected result: event_kind %0d frame_id %0d", out_event_kind, out_frame_id);
      mismatch_count++;
    end else begin
      exp_ev = expected_events.pop_front();
      if (out_event_kind !== exp_ev.kind) begin
        $error("event_kind: expected %0d, got %0d", exp_ev.kind, out_event_kind);
        mismatch_count++;
      end
      if (out_frame_id !== exp_ev.frame_id) begin
        $error("frame_id: expected %0d, got %0d", exp_ev.frame_id, out_frame_id);
        mismatch_count++;
      end
      if (out_frame_length !== exp_ev.frame_length) begin
        $error("frame_length: expected %0d, got %0d", exp_ev.frame_length, out_frame_length);
        mismatch_count++;
      end
      if (out_payload_index !== exp_ev.index) begin
        $error("payload_index: expected %0d, got %0d", exp_ev.index, out_payload_index);
        mismatch_count++;
      end
      if (out_payload_byte !== exp_ev.data) begin
        $error("payload_byte: expected %0d, got %0d", exp_ev.data, out_payload_byte);
        mismatch_count++;
      end
      case (exp_ev.kind)
        EV_PAYLOAD: payload_count++;
        EV_GOOD:    good_count++;
        EV_HDR_ERR: hdr_err_count++;
        default:    sum_err_count++;
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ph       = PH_HUNT;
      cur_id   = '0;
      decl_len = '0;
      rx_count = '0;
      run_sum  = '0;
      expected_events.delete();
      pending_count <= 0;
    end else begin
      if (in_valid === 1'b1 && in_stall === 1'b0) parse_rx_byte(in_rx_byte);
      if (out_valid === 1'b1 && out_stall === 1'b0) check_result();
      pending_count <= expected_events.size();
    end
  end

endmodule

### test/testbench.sv
// Top of the frame parser test: clock, reset, byte stream and verdict.
// Instantiates marker_length_checksum_frame_parser and parser_event_checker.
// Depends on mlcfp_pkg.
`timescale 1ns / 1ps

module testbench;

  import mlcfp_pkg::*;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic [KIND_W-1:0] out_event_kind;
  logic [BYTE_W-1:0] out_frame_id;
  logic [BYTE_W-1:0] out_frame_length;
  logic [BYTE_W-1:0] out_payload_index;
  logic [BYTE_W-1:0] out_payload_byte;

  // Idling knobs, in percent of cycles.
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // Bookkeeping for the summary; noise bytes outside frames are not counted.
  int frame_byte_count = 0;
  int frame_count      = 0;

  int mismatch_count;
  int pending_count;
  int good_count;
  int hdr_err_count;
  int sum_err_count;
  int payload_count;

  marker_length_checksum_frame_parser uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_kind    (out_event_kind),
    .out_frame_id      (out_frame_id),
    .out_frame_length  (out_frame_length),
    .out_payload_index (out_payload_index),
    .out_payload_byte  (out_payload_byte)
  );

  parser_event_checker event_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_kind    (out_event_kind),
    .out_frame_id      (out_frame_id),
    .out_frame_length  (out_frame_length),
    .out_payload_index (out_payload_index),
    .out_payload_byte  (out_payload_byte),
    .mismatch_count    (mismatch_count),
    .pending_count     (pending_count),
    .good_count        (good_count),
    .hdr_err_count     (hdr_err_count),
    .sum_err_count     (sum_err_count),
    .payload_count     (payload_count)
  );

  // 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver side: stall at random, one decision per cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Hand one byte to the parser. Idle cycles come first, with junk on the
  // data lines while valid is low; once valid is raised, hold the byte until
  // the transaction completes.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid   <= 1'b0;
      in_rx_byte <= 8'($urandom);
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic frame_byte(input logic [BYTE_W-1:0] b);
    send_byte(b);
    frame_byte_count++;
  endtask

  // Drop valid and hold off until every predicted event has come out. The
  // first edge lets the checker take in the last accepted byte.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Send one frame with random content. With errors allowed, corrupt the
  // header check byte or the checksum now and then; a rejected header ends
  // the frame, since the parser is back to hunting after it.
  task automatic random_frame(input int len, input bit allow_errors);
    logic [BYTE_W-1:0] id;
    logic [BYTE_W-1:0] len8;
    logic [BYTE_W-1:0] hchk;
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    bit                bad_hdr;
    len8    = len[7:0];
    id      = 8'($urandom);
    hchk    = id + len8;
    sum     = '0;
    bad_hdr = allow_errors && ($urandom_range(99) < 10);
    // A little line noise between frames, never a marker.
    repeat ($urandom_range(2)) begin
      b = 8'($urandom);
      if (b == START_MARKER) b = ~b;
      send_byte(b);
    end
    if (bad_hdr) hchk = hchk ^ 8'($urandom_range(255, 1));
    frame_byte(START_MARKER);
    frame_byte(id);
    frame_byte(len8);
    frame_byte(hchk);
    frame_count++;
    if (!bad_hdr) begin
      for (int i = 0; i < len; i++) begin
        b = 8'($urandom);
        // Plant markers in the payload: they must count as data.
        if ($urandom_range(9) == 0) b = START_MARKER;
        sum = sum + b;
        frame_byte(b);
      end
      if (allow_errors && $urandom_range(99) < 10) sum = sum ^ 8'($urandom_range(255, 1));
      frame_byte(sum);
    end
  endtask

  // One idling setting: mostly well-formed frames, some raw noise bursts
  // that may knock the parser out of step, and an occasional full drain.
  task automatic run_phase(input int snd_pct, input int stl_pct, input int budget);
    int target;
    int r;
    send_idle_pct = snd_pct;
    stall_pct     = stl_pct;
    target        = frame_byte_count + budget;
    while (frame_byte_count < target) begin
      r = $urandom_range(99);
      if (r < 5) begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
      end else if (r < 70) begin
        random_frame($urandom_range(6), 1'b1);
      end else if (r < 95) begin
        random_frame($urandom_range(32, 7), 1'b1);
      end else begin
        random_frame($urandom_range(80, 33), 1'b1);
      end
      if ($urandom_range(99) < 3) drain_results();
    end
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, no idling.
    // Bytes outside a frame: ignored.
    send_byte(8'h00);
    send_byte(8'hFF);
    // Zero length: the byte after the header is the checksum.
    send_byte(START_MARKER);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    // Marker as id and inside the payload: plain data.
    send_byte(START_MARKER);
    send_byte(START_MARKER);
    send_byte(8'h02);
    send_byte(8'h40);
    send_byte(START_MARKER);
    send_byte(8'hFF);
    send_byte(8'h3D);
    // Header check byte wrong: header error.
    send_byte(START_MARKER);
    send_byte(8'h12);
    send_byte(8'h03);
    send_byte(8'h00);
    // Checksum wrong: data checksum error.
    send_byte(START_MARKER);
    send_byte(8'h01);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'hAA);
    send_byte(8'h55);
    frame_byte_count += 22;
    frame_count      += 4;
    drain_results();

    // Random part over the idling settings.
    run_phase(0, 0, 125);
    run_phase(52, 0, 125);
    run_phase(0, 52, 125);
    // Last setting opens with one frame of the largest length, so the
    // payload index runs up to 254.
    send_idle_pct = 16;
    stall_pct     = 16;
    random_frame(255, 1'b0);
    run_phase(16, 16, 125);

    // Let the pipeline settle, then give the verdict.
    stall_pct = 0;
    drain_results();
    repeat (8) @(posedge clk);

    $display("sent %0d frame bytes in %0d frames over four idling settings",
             frame_byte_count, frame_count);
    $display("checked %0d payload bytes, %0d good, %0d header errors, %0d checksum errors",
             payload_count, good_count, hdr_err_count, sum_err_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
